>>> hw/rtl/edd_pkg.sv
// shared types, constants and arithmetic helpers of the error diffusion dither
// no dependencies, used by every module of the block but edd_ram
`default_nettype none

package edd_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ADDR_W    = COL_W + 1;
    localparam int LW_W      = 11;
    localparam int CMP_W     = ((LW_W > COL_W + 1) ? LW_W : COL_W + 1) + 1;
    localparam int ERR_W     = 14;
    localparam int ACC_W     = 16;

    localparam logic [CMP_W-1:0]        MAX_WIDTH_C = CMP_W'(MAX_WIDTH);
    localparam logic [LW_W-1:0]         WIDTH_RESET = LW_W'(384);
    localparam logic signed [ACC_W-1:0] FULL_WHITE  = ACC_W'(4080);
    localparam logic signed [ACC_W-1:0] MID_LEVEL   = ACC_W'(2032);
    localparam logic signed [ACC_W-1:0] ERR_MAX     = ACC_W'(8191);
    localparam logic signed [ACC_W-1:0] ERR_MIN     = -ACC_W'(8192);
    localparam logic [7:0]              PLAIN_LEVEL = 8'd127;

    typedef enum logic [1:0] {
        MODE_FLOYD     = 2'd0,
        MODE_ATKINSON  = 2'd1,
        MODE_BAYER     = 2'd2,
        MODE_THRESHOLD = 2'd3
    } mode_t;

    typedef enum logic {
        REG_MODE       = 1'b0,
        REG_LINE_WIDTH = 1'b1
    } reg_index_t;

    // one store entry: frame tag and error in 1/16 gray steps
    typedef struct packed {
        logic                    tag;
        logic signed [ERR_W-1:0] val;
    } store_word_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        store_word_t       data;
    } store_wr_t;

    // per item position info, settled when the item is taken
    typedef struct packed {
        logic [7:0]       gray;
        logic             frame_start;
        logic [COL_W-1:0] col;
        logic             row_par;
        logic             first_row;
        logic             tag;
        logic [1:0]       phase;
        logic             last;
        logic             near_end;
    } item_t;

    typedef struct packed {
        logic s1_valid;
        logic commit;
    } core_status_t;

    function automatic logic signed [ERR_W-1:0] sat14(input logic signed [ACC_W-1:0] v);
        logic signed [ERR_W-1:0] r;
        if (v > ERR_MAX) begin
            r = ERR_MAX[ERR_W-1:0];
        end else if (v < ERR_MIN) begin
            r = ERR_MIN[ERR_W-1:0];
        end else begin
            r = v[ERR_W-1:0];
        end
        return r;
    endfunction

    // divide by 16, rounding toward zero
    function automatic logic signed [ACC_W-1:0] div16tz(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v < 0) begin
            r = (v + ACC_W'(15)) >>> 4;
        end else begin
            r = v >>> 4;
        end
        return r;
    endfunction

    // divide by 8, rounding toward zero
    function automatic logic signed [ACC_W-1:0] div8tz(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v < 0) begin
            r = (v + ACC_W'(7)) >>> 3;
        end else begin
            r = v >>> 3;
        end
        return r;
    endfunction

    function automatic logic [7:0] bayer_level(input logic [1:0] row, input logic [1:0] col);
        logic [7:0] r;
        unique case ({row, col})
            4'h0: r = 8'd0;
            4'h1: r = 8'd128;
            4'h2: r = 8'd32;
            4'h3: r = 8'd160;
            4'h4: r = 8'd192;
            4'h5: r = 8'd64;
            4'h6: r = 8'd224;
            4'h7: r = 8'd96;
            4'h8: r = 8'd48;
            4'h9: r = 8'd176;
            4'hA: r = 8'd16;
            4'hB: r = 8'd144;
            4'hC: r = 8'd240;
            4'hD: r = 8'd112;
            4'hE: r = 8'd208;
            default: r = 8'd80;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/edd_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module edd_ram #(
    parameter int ADDR_BITS = 11,
    parameter int DATA_BITS = 15
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // a write to the address being read in the same cycle is passed through
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/edd_front.sv
// position tracking: column, row parity, row phase, frame tag, store read addresses
// depends on edd_pkg
`default_nettype none

module edd_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic [7:0]                  gray,
    input  wire logic                        frame_start,
    input  wire logic [edd_pkg::LW_W-1:0]    line_width,
    output edd_pkg::item_t                   item,
    output logic      [edd_pkg::ADDR_W-1:0]  e_raddr,
    output logic      [edd_pkg::ADDR_W-1:0]  d_raddr
);

    logic [edd_pkg::COL_W-1:0] col_reg, col_next;
    logic                      row_par_reg, row_par_next;
    logic                      first_reg, first_next;
    logic                      tag_reg, tag_next;
    logic [1:0]                phase_reg, phase_next;
    logic [edd_pkg::CMP_W-1:0] w_eff;
    logic [edd_pkg::CMP_W-1:0] lw;
    logic [edd_pkg::CMP_W-1:0] x1;

    always_comb begin
        lw = edd_pkg::CMP_W'(line_width);
        if (lw == '0) begin
            w_eff = edd_pkg::CMP_W'(1);
        end else if (lw > edd_pkg::MAX_WIDTH_C) begin
            w_eff = edd_pkg::MAX_WIDTH_C;
        end else begin
            w_eff = lw;
        end

        item.gray        = gray;
        item.frame_start = frame_start;
        item.col         = frame_start ? '0 : col_reg;
        item.row_par     = frame_start ? 1'b0 : row_par_reg;
        item.first_row   = frame_start ? 1'b1 : first_reg;
        item.tag         = frame_start ? ~tag_reg : tag_reg;
        item.phase       = frame_start ? 2'd0 : phase_reg;

        x1            = edd_pkg::CMP_W'(item.col) + edd_pkg::CMP_W'(1);
        item.last     = (x1 >= w_eff);
        item.near_end = ((x1 + edd_pkg::CMP_W'(1)) >= w_eff);

        tag_next = item.tag;
        if (item.last) begin
            col_next     = '0;
            row_par_next = ~item.row_par;
            phase_next   = item.phase + 2'd1;
            first_next   = 1'b0;
        end else begin
            col_next     = item.col + edd_pkg::COL_W'(1);
            row_par_next = item.row_par;
            phase_next   = item.phase;
            first_next   = item.first_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_par_reg <= 1'b0;
            first_reg   <= 1'b1;
            tag_reg     <= 1'b0;
            phase_reg   <= 2'd0;
        end else if (accept) begin
            col_reg     <= col_next;
            row_par_reg <= row_par_next;
            first_reg   <= first_next;
            tag_reg     <= tag_next;
            phase_reg   <= phase_next;
        end
    end

    // current row errors sit in row_par, previous row's two-down terms in the other half
    assign e_raddr = {item.row_par, item.col};
    assign d_raddr = {~item.row_par, item.col};

endmodule

`default_nettype wire

>>> hw/rtl/edd_core.sv
// quantizer and error spreading stage with output register
// depends on edd_pkg
`default_nettype none

module edd_core (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  edd_pkg::item_t             item,
    input  edd_pkg::mode_t             mode,
    input  edd_pkg::store_word_t       e_rdata,
    input  edd_pkg::store_word_t       d_rdata,
    output edd_pkg::store_wr_t         e_wr,
    output edd_pkg::store_wr_t         d_wr,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_dot,
    output logic                       m_last,
    output edd_pkg::core_status_t      status
);

    localparam int ACC_W = edd_pkg::ACC_W;
    localparam int ERR_W = edd_pkg::ERR_W;

    logic                        s1_valid_reg;
    edd_pkg::item_t              s1_item_reg;
    logic                        m_valid_reg;
    logic                        m_dot_reg;
    logic                        m_last_reg;
    logic signed [ERR_W-1:0]     re0_reg, re0_next;
    logic signed [ERR_W-1:0]     re1_reg, re1_next;
    logic signed [ACC_W-1:0]     dr_reg;
    logic signed [ACC_W-1:0]     partial_reg;
    logic                        def_valid_reg;
    logic [edd_pkg::ADDR_W-1:0]  def_addr_reg;
    edd_pkg::store_word_t        def_data_reg;

    logic                        out_free;
    logic                        commit;
    logic signed [ERR_W-1:0]     re0_eff, re1_eff, e_val, base;
    logic signed [ACC_W-1:0]     v, vc, err;
    logic signed [ACC_W-1:0]     err3, err5, err7, e8;
    logic signed [ACC_W-1:0]     t_r1, t_r2, t_dl, t_d, t_dr, t_dd;
    logic signed [ACC_W-1:0]     r1k, r2k, dr_eff, partial;
    logic                        white, dot;
    logic                        col_zero;

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;

    always_comb begin
        re0_eff  = s1_item_reg.frame_start ? '0 : re0_reg;
        re1_eff  = s1_item_reg.frame_start ? '0 : re1_reg;
        e_val    = (!s1_item_reg.first_row && (e_rdata.tag == s1_item_reg.tag))
                   ? e_rdata.val : '0;
        base     = (!s1_item_reg.first_row && (d_rdata.tag == s1_item_reg.tag))
                   ? d_rdata.val : '0;
        col_zero = (s1_item_reg.col == '0);

        v = signed'({{(ACC_W-12){1'b0}}, s1_item_reg.gray, 4'b0000})
            + ACC_W'(re0_eff) + ACC_W'(e_val);
        if (v < 0) begin
            vc = '0;
        end else if (v > edd_pkg::FULL_WHITE) begin
            vc = edd_pkg::FULL_WHITE;
        end else begin
            vc = v;
        end
        white = (vc > edd_pkg::MID_LEVEL);
        err   = white ? (vc - edd_pkg::FULL_WHITE) : vc;

        err3 = (err <<< 1) + err;
        err5 = (err <<< 2) + err;
        err7 = (err <<< 3) - err;
        e8   = edd_pkg::div8tz(err);

        t_r1 = '0;
        t_r2 = '0;
        t_dl = '0;
        t_d  = '0;
        t_dr = '0;
        t_dd = '0;
        unique case (mode)
            edd_pkg::MODE_FLOYD: begin
                t_r1 = edd_pkg::div16tz(err7);
                t_dl = edd_pkg::div16tz(err3);
                t_d  = edd_pkg::div16tz(err5);
                t_dr = edd_pkg::div16tz(err);
                dot  = !white;
            end
            edd_pkg::MODE_ATKINSON: begin
                t_r1 = e8;
                t_r2 = e8;
                t_dl = e8;
                t_d  = e8;
                t_dr = e8;
                t_dd = e8;
                dot  = !white;
            end
            edd_pkg::MODE_BAYER: begin
                dot = !(s1_item_reg.gray >
                        edd_pkg::bayer_level(s1_item_reg.phase, s1_item_reg.col[1:0]));
            end
            default: begin
                dot = !(s1_item_reg.gray > edd_pkg::PLAIN_LEVEL);
            end
        endcase

        // terms past the right edge are dropped
        r1k     = s1_item_reg.last ? '0 : t_r1;
        r2k     = s1_item_reg.near_end ? '0 : t_r2;
        dr_eff  = col_zero ? '0 : dr_reg;
        partial = ACC_W'(base) + dr_eff + t_d;

        if (s1_item_reg.last) begin
            re0_next = '0;
            re1_next = '0;
        end else begin
            re0_next = edd_pkg::sat14(ACC_W'(re1_eff) + r1k);
            re1_next = edd_pkg::sat14(r2k);
        end
    end

    // next-row entry x-1 is complete once this item's down-left term is in
    always_comb begin
        e_wr.en        = commit;
        e_wr.data.tag  = s1_item_reg.tag;
        if (!col_zero) begin
            e_wr.addr     = {~s1_item_reg.row_par, s1_item_reg.col - edd_pkg::COL_W'(1)};
            e_wr.data.val = edd_pkg::sat14(partial_reg + t_dl);
        end else if (s1_item_reg.last) begin
            e_wr.addr     = {~s1_item_reg.row_par, s1_item_reg.col};
            e_wr.data.val = edd_pkg::sat14(partial);
        end else begin
            e_wr.en   = commit && def_valid_reg;
            e_wr.addr = def_addr_reg;
            e_wr.data = def_data_reg;
        end

        d_wr.en       = commit;
        d_wr.addr     = {s1_item_reg.row_par, s1_item_reg.col};
        d_wr.data.tag = s1_item_reg.tag;
        d_wr.data.val = edd_pkg::sat14(t_dd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            def_valid_reg <= 1'b0;
            re0_reg       <= '0;
            re1_reg       <= '0;
        end else begin
            if (s_valid && s_ready) begin
                s1_valid_reg <= 1'b1;
            end else if (commit) begin
                s1_valid_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
                re0_reg     <= re0_next;
                re1_reg     <= re1_next;
                if (s1_item_reg.last && !col_zero) begin
                    def_valid_reg <= 1'b1;
                end else if (col_zero) begin
                    def_valid_reg <= 1'b0;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_item_reg <= item;
        end
        if (commit) begin
            m_dot_reg         <= dot;
            m_last_reg        <= s1_item_reg.last;
            dr_reg            <= t_dr;
            partial_reg       <= partial;
            def_addr_reg      <= {~s1_item_reg.row_par, s1_item_reg.col};
            def_data_reg.tag  <= s1_item_reg.tag;
            def_data_reg.val  <= edd_pkg::sat14(partial);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_dot           = m_dot_reg;
    assign m_last          = m_last_reg;
    assign status.s1_valid = s1_valid_reg;
    assign status.commit   = commit;

endmodule

`default_nettype wire

>>> hw/rtl/error_diffusion_dither.sv
// top level of the error diffusion dither: config registers, two error stores, front and core
// depends on edd_pkg, edd_ram, edd_front, edd_core
`default_nettype none

// channel   dir  handshake          payload
// s_        in   tvalid / tready    tdata[7:0] gray, tuser[0] frame_start
// m_        out  tvalid / tready    tdata[0] dot (upper bits zero), tlast row_end
// cfg_      in   cfg_wr_en          cfg_index, cfg_wdata (mode or line_width)
//
// one item per clock sustained while the output register is not held; an item taken is read from the
// stores on the accept edge, then quantized and spread into the output register when that is free
// the rate is set by the right-neighbor error loop, an add back into itself
// synchronous active-low reset clears config, position, pending errors and handshake state only;
// the stores carry a frame tag per entry, so there is no clearing pass after reset
// s_tready drops only while the working stage is full and the output register is held

module error_diffusion_dither (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] gray
    input  wire logic [0:0]               s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [7:0]               m_tdata,   // [0] dot, [7:1] zero
    output logic                          m_tlast,
    input  wire logic                     cfg_wr_en,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [edd_pkg::LW_W-1:0] cfg_wdata
);

    edd_pkg::mode_t             mode_reg;
    logic [edd_pkg::LW_W-1:0]   width_reg;
    logic                       s_acc;
    edd_pkg::item_t             item;
    logic [edd_pkg::ADDR_W-1:0] e_raddr, d_raddr;
    edd_pkg::store_word_t       e_rdata, d_rdata;
    edd_pkg::store_wr_t         e_wr, d_wr;
    edd_pkg::core_status_t      status;
    logic                       dot;

    // config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= edd_pkg::MODE_FLOYD;
            width_reg <= edd_pkg::WIDTH_RESET;
        end else if (cfg_wr_en) begin
            unique case (edd_pkg::reg_index_t'(cfg_index))
                edd_pkg::REG_MODE:       mode_reg  <= edd_pkg::mode_t'(cfg_wdata[1:0]);
                edd_pkg::REG_LINE_WIDTH: width_reg <= cfg_wdata;
                default:                 width_reg <= width_reg;
            endcase
        end
    end

    assign s_acc = s_tvalid && s_tready;

    // position tracking and read addresses for the incoming item
    edd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_acc),
        .gray        (s_tdata),
        .frame_start (s_tuser[0]),
        .line_width  (width_reg),
        .item        (item),
        .e_raddr     (e_raddr),
        .d_raddr     (d_raddr)
    );

    // finished errors for the current and the next row, ping-pong halves
    edd_ram #(
        .ADDR_BITS (edd_pkg::ADDR_W),
        .DATA_BITS ($bits(edd_pkg::store_word_t))
    ) u_err_ram (
        .aclk    (aclk),
        .wr_en   (e_wr.en),
        .wr_addr (e_wr.addr),
        .wr_data (e_wr.data),
        .rd_en   (s_acc),
        .rd_addr (e_raddr),
        .rd_data (e_rdata)
    );

    // two-rows-down terms (atkinson), read back as the base of the next row
    edd_ram #(
        .ADDR_BITS (edd_pkg::ADDR_W),
        .DATA_BITS ($bits(edd_pkg::store_word_t))
    ) u_far_ram (
        .aclk    (aclk),
        .wr_en   (d_wr.en),
        .wr_addr (d_wr.addr),
        .wr_data (d_wr.data),
        .rd_en   (s_acc),
        .rd_addr (d_raddr),
        .rd_data (d_rdata)
    );

    // quantize, spread error, write back, hold the result item
    edd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .item    (item),
        .mode    (mode_reg),
        .e_rdata (e_rdata),
        .d_rdata (d_rdata),
        .e_wr    (e_wr),
        .d_wr    (d_wr),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_dot   (dot),
        .m_last  (m_tlast),
        .status  (status)
    );

    assign m_tdata = {7'b0000000, dot};

`ifndef SYNTHESIS
    // a new item only enters a full working stage when the old one moves on
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && status.s1_valid) |-> status.commit)
        else $error("item taken while working stage is stuck");

    // a committed item always shows up on the result side
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        status.commit |=> m_tvalid)
        else $error("committed item did not reach the output register");

    // the item after a row end starts at column zero
    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && item.last) |=> (item.col == '0))
        else $error("column did not wrap after row end");
`endif

endmodule

`default_nettype wire
